[rtl/core/motor_command_frame_encoder_core_defines.svh]
// Assertion macros for the motor command frame encoder.
// Each macro checks a property on the rising edge of clk while rst_n is high.
// Define ASSERT_OFF to compile the assertions out.
`ifndef MOTOR_COMMAND_FRAME_ENCODER_CORE_DEFINES_SVH
`define MOTOR_COMMAND_FRAME_ENCODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define MCFE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mcfe assertion failed");
`define MCFE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcfe assertion failed");
`else
`define MCFE_ASSERT(lbl, prop)
`define MCFE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/core/mcfe_pkg.sv]
package mcfe_pkg;

  // Fixed sizes of the command and of the type map.
  localparam int MOTOR_COUNT = 7;
  localparam int CFG_W       = 7;
  localparam int FRAC_BITS   = 16;
  localparam int VAL_W       = 32;

  // Width for limit compares; the widest limit is 500 with FRAC_BITS fraction bits.
  localparam int CMP_W  = (FRAC_BITS + 11 > VAL_W + 1) ? FRAC_BITS + 11 : VAL_W + 1;
  // Offset from the lower limit, at most 1000 half units.
  localparam int OFF_W  = FRAC_BITS + 10;
  localparam int POS_BITS  = 16;
  localparam int GAIN_BITS = 12;
  localparam int CODE_W = POS_BITS;
  localparam int OFFX_W = OFF_W + POS_BITS;
  // Scaled offset in half units times the code range: at most 1000 * 4095.
  localparam int T_W    = 23;
  localparam int SPAN_W = 10;

  // Reciprocal scaling for the division by the span in half units.
  localparam int RCP_SH = 24;
  localparam int RCP_W  = 21;
  localparam int PROD_W = T_W + RCP_W;

  // Limits in half units.
  localparam int HALF_POS   = 25;
  localparam int HALF_VEL_S = 60;
  localparam int HALF_VEL_L = 20;
  localparam int HALF_KP    = 1000;
  localparam int HALF_KD    = 10;
  localparam int HALF_TQ_S  = 20;
  localparam int HALF_TQ_L  = 56;

  localparam int RCP_POS   = (1 << RCP_SH) / (2 * HALF_POS);
  localparam int RCP_VEL_S = (1 << RCP_SH) / (2 * HALF_VEL_S);
  localparam int RCP_VEL_L = (1 << RCP_SH) / (2 * HALF_VEL_L);
  localparam int RCP_KP    = (1 << RCP_SH) / HALF_KP;
  localparam int RCP_KD    = (1 << RCP_SH) / HALF_KD;
  localparam int RCP_TQ_S  = (1 << RCP_SH) / (2 * HALF_TQ_S);
  localparam int RCP_TQ_L  = (1 << RCP_SH) / (2 * HALF_TQ_L);

  localparam longint FIX_HALF = longint'(1) << (FRAC_BITS - 1);
  localparam int EXP_BIAS = 127 - FRAC_BITS;

  // Mode and motor type codes.
  localparam logic [1:0] MODE_MIT = 2'd0;
  localparam logic [1:0] MODE_PV  = 2'd1;
  localparam logic [1:0] TYPE_UNKNOWN = 2'd0;
  localparam logic [1:0] TYPE_SMALL   = 2'd1;
  localparam logic [1:0] TYPE_LARGE   = 2'd2;

  typedef enum logic [3:0] {
    ERR_NONE          = 4'd0,
    ERR_INDEX         = 4'd1,
    ERR_TYPE_UNKNOWN  = 4'd2,
    ERR_TYPE_MISMATCH = 4'd3,
    ERR_POSITION      = 4'd4,
    ERR_VELOCITY      = 4'd5,
    ERR_TORQUE        = 4'd6,
    ERR_KP            = 4'd7,
    ERR_KD            = 4'd8,
    ERR_MODE          = 4'd9
  } mcfe_err_t;

  typedef enum logic [2:0] {
    QTY_POS,
    QTY_VEL,
    QTY_KP,
    QTY_KD,
    QTY_TQ
  } mcfe_qty_t;

  // Load strobes of the inner pipeline stages.
  typedef struct packed {
    logic ld_b;
    logic ld_c;
  } mcfe_ld_t;

  // Upper limit in half units.
  function automatic int lim_hi2(logic is_large, mcfe_qty_t qty);
    int h;
    case (qty)
      QTY_POS: h = HALF_POS;
      QTY_VEL: h = is_large ? HALF_VEL_L : HALF_VEL_S;
      QTY_KP:  h = HALF_KP;
      QTY_KD:  h = HALF_KD;
      QTY_TQ:  h = is_large ? HALF_TQ_L : HALF_TQ_S;
      default: h = 0;
    endcase
    return h;
  endfunction

  // Lower limit in half units: gains start at zero, the rest is symmetric.
  function automatic int lim_lo2(logic is_large, mcfe_qty_t qty);
    int h;
    case (qty)
      QTY_KP:  h = 0;
      QTY_KD:  h = 0;
      default: h = -lim_hi2(is_large, qty);
    endcase
    return h;
  endfunction

  function automatic logic signed [CMP_W-1:0] half_to_fix(int half);
    return CMP_W'(longint'(half) * FIX_HALF);
  endfunction

  function automatic logic signed [CMP_W-1:0] lim_hi(logic is_large, mcfe_qty_t qty);
    return half_to_fix(lim_hi2(is_large, qty));
  endfunction

  function automatic logic signed [CMP_W-1:0] lim_lo(logic is_large, mcfe_qty_t qty);
    return half_to_fix(lim_lo2(is_large, qty));
  endfunction

  // Span in half units.
  function automatic logic [SPAN_W-1:0] span_sel(logic is_large, mcfe_qty_t qty);
    return SPAN_W'(lim_hi2(is_large, qty) - lim_lo2(is_large, qty));
  endfunction

  function automatic logic [RCP_W-1:0] rcp_sel(logic is_large, mcfe_qty_t qty);
    int r;
    case (qty)
      QTY_POS: r = RCP_POS;
      QTY_VEL: r = is_large ? RCP_VEL_L : RCP_VEL_S;
      QTY_KP:  r = RCP_KP;
      QTY_KD:  r = RCP_KD;
      QTY_TQ:  r = is_large ? RCP_TQ_L : RCP_TQ_S;
      default: r = 0;
    endcase
    return RCP_W'(r);
  endfunction

endpackage

[rtl/core/mcfe_check.sv]
module mcfe_check import mcfe_pkg::*; (
  input  logic [2:0]              slot_index,
  input  logic [1:0]              motor_kind,
  input  logic [1:0]              mode,
  input  logic signed [VAL_W-1:0] position,
  input  logic signed [VAL_W-1:0] velocity,
  input  logic signed [VAL_W-1:0] stiffness_gain,
  input  logic signed [VAL_W-1:0] damping_gain,
  input  logic signed [VAL_W-1:0] torque,
  input  logic [CFG_W-1:0]        cfg_types,
  output mcfe_err_t               err
);

  function automatic logic in_lim(logic signed [VAL_W-1:0] v, logic big, mcfe_qty_t qty);
    logic signed [CMP_W-1:0] vx;
    vx = CMP_W'(v);
    return (vx >= lim_lo(big, qty)) && (vx <= lim_hi(big, qty));
  endfunction

  logic                    is_large;
  logic                    want_small;
  logic [1:0]              want_type;
  logic signed [CMP_W-1:0] vel_x;
  logic                    vel_ok;

  // Limits follow the commanded type; it equals the mapped type once checked.
  assign is_large   = (motor_kind == TYPE_LARGE);
  assign want_small = ({1'b0, slot_index} < 4'(CFG_W)) && cfg_types[slot_index];
  assign want_type  = want_small ? TYPE_SMALL : TYPE_LARGE;
  assign vel_x      = CMP_W'(velocity);

  // Position-velocity mode needs a strictly positive velocity limit.
  always_comb begin
    if (mode == MODE_PV) begin
      vel_ok = !vel_x[CMP_W-1] && (vel_x != CMP_W'(0)) &&
               (vel_x <= lim_hi(is_large, QTY_VEL));
    end else begin
      vel_ok = in_lim(velocity, is_large, QTY_VEL);
    end
  end

  // First failing check wins.
  always_comb begin
    if ({1'b0, slot_index} >= 4'(MOTOR_COUNT)) begin
      err = ERR_INDEX;
    end else if (motor_kind == TYPE_UNKNOWN) begin
      err = ERR_TYPE_UNKNOWN;
    end else if (motor_kind != want_type) begin
      err = ERR_TYPE_MISMATCH;
    end else if (!in_lim(position, is_large, QTY_POS)) begin
      err = ERR_POSITION;
    end else if (!vel_ok) begin
      err = ERR_VELOCITY;
    end else if (mode == MODE_MIT && !in_lim(torque, is_large, QTY_TQ)) begin
      err = ERR_TORQUE;
    end else if (mode == MODE_MIT && !in_lim(stiffness_gain, is_large, QTY_KP)) begin
      err = ERR_KP;
    end else if (mode == MODE_MIT && !in_lim(damping_gain, is_large, QTY_KD)) begin
      err = ERR_KD;
    end else if (mode != MODE_MIT && mode != MODE_PV) begin
      err = ERR_MODE;
    end else begin
      err = ERR_NONE;
    end
  end

endmodule

[rtl/core/mcfe_quant_lane.sv]
module mcfe_quant_lane import mcfe_pkg::*; (
  input  logic                    clk,
  input  logic signed [VAL_W-1:0] value,
  input  mcfe_qty_t               qty,
  input  logic                    is_large,
  input  mcfe_ld_t                ld,
  output logic [CODE_W-1:0]       code
);

  logic signed [CMP_W-1:0] diff;
  logic [OFF_W-1:0]        off;
  logic [OFFX_W-1:0]       offx;
  logic [T_W-1:0]          t_b_nxt;
  logic [T_W-1:0]          t_b_r;
  logic                    large_b_r;
  logic [PROD_W-1:0]       prod;
  logic [CODE_W-1:0]       q0_c_r;
  logic [T_W-1:0]          t_c_r;
  logic                    large_c_r;
  logic [SPAN_W-1:0]       span;
  logic [T_W-1:0]          rem;

  // Offset from the lower limit times the code range, in half units.
  // The value is in range whenever the code is used.
  assign diff = CMP_W'(value) - lim_lo(is_large, qty);
  assign off  = diff[OFF_W-1:0];
  always_comb begin
    if (qty == QTY_POS) begin
      offx = (OFFX_W'(off) << POS_BITS) - OFFX_W'(off);
    end else begin
      offx = (OFFX_W'(off) << GAIN_BITS) - OFFX_W'(off);
    end
  end
  assign t_b_nxt = offx[FRAC_BITS-1 +: T_W];

  always_ff @(posedge clk) begin
    if (ld.ld_b) begin
      t_b_r     <= t_b_nxt;
      large_b_r <= is_large;
    end
  end

  // Quotient estimate by the reciprocal of the span; at most one low.
  assign prod = PROD_W'(t_b_r) * PROD_W'(rcp_sel(large_b_r, qty));

  always_ff @(posedge clk) begin
    if (ld.ld_c) begin
      q0_c_r    <= prod[RCP_SH +: CODE_W];
      t_c_r     <= t_b_r;
      large_c_r <= large_b_r;
    end
  end

  // Correct the estimate by the remainder.
  assign span = span_sel(large_c_r, qty);
  assign rem  = t_c_r - T_W'(T_W'(q0_c_r) * T_W'(span));
  assign code = (rem >= T_W'(span)) ? q0_c_r + CODE_W'(1) : q0_c_r;

endmodule

[rtl/core/mcfe_f32_lane.sv]
module mcfe_f32_lane import mcfe_pkg::*; (
  input  logic                    clk,
  input  logic signed [VAL_W-1:0] value,
  input  mcfe_ld_t                ld,
  output logic [31:0]             bytes_le
);

  logic        neg;
  logic [31:0] mag;
  logic [4:0]  lead;
  logic [31:0] mag_b_r;
  logic [4:0]  lead_b_r;
  logic        neg_b_r;
  logic        zero_b_r;
  logic [31:0] norm;
  logic [31:0] norm_c_r;
  logic [4:0]  lead_c_r;
  logic        neg_c_r;
  logic        zero_c_r;
  logic [23:0] mant;
  logic        round_up;
  logic [24:0] rsum;
  logic [23:0] mant_f;
  logic [5:0]  lead_f;
  logic [7:0]  expo;
  logic [31:0] f32;

  // Magnitude and position of its leading one.
  assign neg = value[VAL_W-1];
  assign mag = neg ? (~32'(value) + 32'd1) : 32'(value);
  always_comb begin
    lead = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) begin
        lead = 5'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_b) begin
      mag_b_r  <= mag;
      lead_b_r <= lead;
      neg_b_r  <= neg;
      zero_b_r <= (mag == 32'd0);
    end
  end

  // Normalize so the leading one sits in bit 31.
  assign norm = mag_b_r << (5'd31 - lead_b_r);

  always_ff @(posedge clk) begin
    if (ld.ld_c) begin
      norm_c_r <= norm;
      lead_c_r <= lead_b_r;
      neg_c_r  <= neg_b_r;
      zero_c_r <= zero_b_r;
    end
  end

  // Round to nearest even; a carry out renormalizes by one place.
  assign mant     = norm_c_r[31:8];
  assign round_up = norm_c_r[7] && ((|norm_c_r[6:0]) || mant[0]);
  assign rsum     = {1'b0, mant} + 25'(round_up);
  always_comb begin
    if (rsum[24]) begin
      mant_f = rsum[24:1];
      lead_f = {1'b0, lead_c_r} + 6'd1;
    end else begin
      mant_f = rsum[23:0];
      lead_f = {1'b0, lead_c_r};
    end
  end
  assign expo = 8'(lead_f) + 8'(EXP_BIAS);
  assign f32  = zero_c_r ? 32'd0 : {neg_c_r, expo, mant_f[22:0]};

  // Little-endian byte order in the frame.
  assign bytes_le = {f32[7:0], f32[15:8], f32[23:16], f32[31:24]};

endmodule

[rtl/core/motor_command_frame_encoder_core.sv]
// Motor command frame encoder. Each input word is one motor command; each
// yields exactly one output word with an 8-byte frame and an error code, in
// order. The block is a four-register pipeline (input, check/offset,
// reciprocal multiply and normalize, output) that takes one word every
// cycle unless in_stall is high. in_stall rises only when all four
// registers hold words and the output is stalled. The type map register
// (cfg_wdata, reset value 120) is written with cfg_we; the user must write it
// only while no command is in flight, as the block does not enforce this.
`include "motor_command_frame_encoder_core_defines.svh"

module motor_command_frame_encoder_core import mcfe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_slot_index,
  input  logic [1:0]              in_motor_kind,
  input  logic [1:0]              in_mode,
  input  logic signed [VAL_W-1:0] in_position,
  input  logic signed [VAL_W-1:0] in_velocity,
  input  logic signed [VAL_W-1:0] in_stiffness_gain,
  input  logic signed [VAL_W-1:0] in_damping_gain,
  input  logic signed [VAL_W-1:0] in_torque,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [31:0]             out_frame_high,
  output logic [31:0]             out_frame_low,
  output logic [3:0]              out_error_code
);

  logic [CFG_W-1:0] cfg_types_r;

  logic a_v_r, b_v_r, c_v_r, d_v_r;
  logic a_rdy, b_rdy, c_rdy, d_rdy;
  logic a_ld, b_ld, c_ld, d_ld;
  mcfe_ld_t ld;

  logic [2:0]              a_index_r;
  logic [1:0]              a_type_r;
  logic [1:0]              a_mode_r;
  logic signed [VAL_W-1:0] a_pos_r;
  logic signed [VAL_W-1:0] a_vel_r;
  logic signed [VAL_W-1:0] a_kp_r;
  logic signed [VAL_W-1:0] a_kd_r;
  logic signed [VAL_W-1:0] a_tq_r;
  logic                    a_large;

  mcfe_err_t  err_b_nxt;
  mcfe_err_t  err_b_r, err_c_r, err_d_r;
  logic [1:0] mode_b_r, mode_c_r;

  logic [CODE_W-1:0] pos_code, vel_code, kp_code, kd_code, tq_code;
  logic [31:0]       pos_f32, vel_f32;
  logic [31:0]       frame_high_nxt, frame_low_nxt;
  logic [31:0]       frame_high_r, frame_low_r;
  logic              out_frame_zero;

  // Type map register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_types_r <= CFG_W'(120);
    end else if (cfg_we) begin
      cfg_types_r <= cfg_wdata;
    end
  end

  // Pipeline flow: a stage loads when it is empty or its word moves on.
  assign d_rdy = !d_v_r || !out_stall;
  assign c_rdy = !c_v_r || d_rdy;
  assign b_rdy = !b_v_r || c_rdy;
  assign a_rdy = !a_v_r || b_rdy;
  assign a_ld  = in_valid && a_rdy;
  assign b_ld  = a_v_r && b_rdy;
  assign c_ld  = b_v_r && c_rdy;
  assign d_ld  = c_v_r && d_rdy;
  assign ld.ld_b = b_ld;
  assign ld.ld_c = c_ld;
  assign in_stall = !a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      a_v_r <= a_ld || (a_v_r && !b_ld);
      b_v_r <= b_ld || (b_v_r && !c_ld);
      c_v_r <= c_ld || (c_v_r && !d_ld);
      d_v_r <= d_ld || (d_v_r && out_stall);
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (a_ld) begin
      a_index_r <= in_slot_index;
      a_type_r  <= in_motor_kind;
      a_mode_r  <= in_mode;
      a_pos_r   <= in_position;
      a_vel_r   <= in_velocity;
      a_kp_r    <= in_stiffness_gain;
      a_kd_r    <= in_damping_gain;
      a_tq_r    <= in_torque;
    end
  end

  assign a_large = (a_type_r == TYPE_LARGE);

  // Index, type and limit checks.
  mcfe_check u_check (
    .slot_index     (a_index_r),
    .motor_kind     (a_type_r),
    .mode           (a_mode_r),
    .position       (a_pos_r),
    .velocity       (a_vel_r),
    .stiffness_gain (a_kp_r),
    .damping_gain   (a_kd_r),
    .torque         (a_tq_r),
    .cfg_types      (cfg_types_r),
    .err            (err_b_nxt)
  );

  // Error code and mode travel alongside the lanes.
  always_ff @(posedge clk) begin
    if (b_ld) begin
      err_b_r  <= err_b_nxt;
      mode_b_r <= a_mode_r;
    end
    if (c_ld) begin
      err_c_r  <= err_b_r;
      mode_c_r <= mode_b_r;
    end
  end

  // MIT code lanes.
  mcfe_quant_lane u_q_pos (
    .clk (clk), .value (a_pos_r), .qty (QTY_POS), .is_large (a_large), .ld (ld),
    .code (pos_code)
  );
  mcfe_quant_lane u_q_vel (
    .clk (clk), .value (a_vel_r), .qty (QTY_VEL), .is_large (a_large), .ld (ld),
    .code (vel_code)
  );
  mcfe_quant_lane u_q_kp (
    .clk (clk), .value (a_kp_r), .qty (QTY_KP), .is_large (a_large), .ld (ld),
    .code (kp_code)
  );
  mcfe_quant_lane u_q_kd (
    .clk (clk), .value (a_kd_r), .qty (QTY_KD), .is_large (a_large), .ld (ld),
    .code (kd_code)
  );
  mcfe_quant_lane u_q_tq (
    .clk (clk), .value (a_tq_r), .qty (QTY_TQ), .is_large (a_large), .ld (ld),
    .code (tq_code)
  );

  // Float lanes for position-velocity mode.
  mcfe_f32_lane u_f_pos (
    .clk (clk), .value (a_pos_r), .ld (ld), .bytes_le (pos_f32)
  );
  mcfe_f32_lane u_f_vel (
    .clk (clk), .value (a_vel_r), .ld (ld), .bytes_le (vel_f32)
  );

  // Frame assembly; any error gives an all-zero frame.
  always_comb begin
    frame_high_nxt = 32'd0;
    frame_low_nxt  = 32'd0;
    if (err_c_r == ERR_NONE) begin
      case (mode_c_r)
        MODE_MIT: begin
          frame_high_nxt = {pos_code, vel_code[GAIN_BITS-1:0], kp_code[11:8]};
          frame_low_nxt  = {kp_code[7:0], kd_code[GAIN_BITS-1:0], tq_code[GAIN_BITS-1:0]};
        end
        MODE_PV: begin
          frame_high_nxt = pos_f32;
          frame_low_nxt  = vel_f32;
        end
        default: begin
          frame_high_nxt = 32'd0;
          frame_low_nxt  = 32'd0;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (d_ld) begin
      frame_high_r <= frame_high_nxt;
      frame_low_r  <= frame_low_nxt;
      err_d_r      <= err_c_r;
    end
  end

  assign out_valid      = d_v_r;
  assign out_frame_high = frame_high_r;
  assign out_frame_low  = frame_low_r;
  assign out_error_code = err_d_r;

  assign out_frame_zero = (out_frame_high == 32'd0) && (out_frame_low == 32'd0);

  // A failed command never carries frame data.
  `MCFE_ASSERT(a_err_frame_zero, out_valid && (out_error_code != ERR_NONE) |-> out_frame_zero)
  // Only defined error codes leave the block.
  `MCFE_ASSERT(a_err_code_range, out_valid |-> (out_error_code <= ERR_MODE))
  // Input stalls only when every stage is full and the output is held.
  `MCFE_ASSERT(a_stall_full, in_stall |-> a_v_r && b_v_r && c_v_r && d_v_r && out_stall)
  // A word accepted at the input occupies the input register next cycle.
  `MCFE_ASSERT_NXT(a_accept_fills, in_valid && !in_stall, a_v_r)

endmodule
